// File: hdl/pba_pkg.sv
// Shared types and constants for the pool block allocator.
// No dependencies; the interfaces, controller, datapath and top level import this package.
package pba_pkg;

  localparam int LEN_W    = 32;
  localparam int FIELD_W  = 32;
  localparam int STATUS_W = 4;
  localparam int CFG_IDX_W = 2;

  // request modes
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKED       = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NEW         = 4'd0;
  localparam logic [STATUS_W-1:0] ST_REUSED      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_FREED       = 4'd2;
  localparam logic [STATUS_W-1:0] ST_TOP_REMOVED = 4'd3;
  localparam logic [STATUS_W-1:0] ST_LOCKED      = 4'd4;
  localparam logic [STATUS_W-1:0] ST_BAD         = 4'd5;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_FULL        = 4'd8;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the input beat
    logic prep;    // top entry read or alignment start
    logic scan;    // issue one table read
    logic finish;  // decide, write back, load result
  } pba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic early;      // result known without a table walk
    logic empty;      // table holds no entries
    logic scan_last;  // current scan read is the last entry
    logic busy;       // table read still in flight
  } pba_sts_t;

endpackage

// File: hdl/pba_in_if.sv
// Request channel: valid/ready handshake with the request payload.
// Uses pba_pkg for field widths.
interface pba_in_if;
  import pba_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [FIELD_W-1:0] request_size;
  logic [FIELD_W-1:0] block_address;

  modport source (output valid, mode, request_size, block_address, input ready);
  modport sink   (input valid, mode, request_size, block_address, output ready);
endinterface

// File: hdl/pba_out_if.sv
// Result channel: valid/ready handshake with the result payload.
// Uses pba_pkg for field widths.
interface pba_out_if;
  import pba_pkg::*;

  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  granted_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, granted_address, status, input ready);
  modport sink   (input valid, granted_address, status, output ready);
endinterface

// File: hdl/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pba_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/pba_align.sv
// Rounds an address up to a multiple of ALIGN_BYTES (a power of two) by add and mask.
// Result is registered when start is high. No dependencies.
module pba_align #(
  parameter int ADDR_BITS   = 32,
  parameter int ALIGN_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 start,
  input  logic [ADDR_BITS-1:0] value,
  output logic [ADDR_BITS-1:0] rounded
);

  localparam logic [ADDR_BITS-1:0] LOW_MASK = ADDR_BITS'(ALIGN_BYTES - 1);

  logic [ADDR_BITS-1:0] rounded_r;

  // sum wraps at ADDR_BITS
  always_ff @(posedge clk) begin
    if (start) begin
      rounded_r <= (value + LOW_MASK) & ~LOW_MASK;
    end
  end

  assign rounded = rounded_r;

endmodule

// File: hdl/pba_ctrl.sv
// Sequencer for the allocator: one request at a time through load, table walk,
// drain and finish. Depends on pba_pkg for the command and status structs.
module pba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pba_pkg::pba_sts_t  sts,
  output pba_pkg::pba_cmd_t  cmd
);
  import pba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        priority if (sts.early) state_nxt = S_FIN;
        else if (sts.empty)     state_nxt = S_DRAIN;
        else                    state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: hdl/pba_dpath.sv
// Allocator datapath: config registers, block table RAM, best-fit/lookup walk,
// alignment unit and result registers. Depends on pba_pkg, pba_ram, pba_align.
module pba_dpath #(
  parameter int MAX_BLOCKS  = 64,
  parameter int ADDR_BITS   = 32,
  parameter int ALIGN_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pba_pkg::FIELD_W-1:0]     cfg_data,
  input  logic                            in_mode,
  input  logic [pba_pkg::FIELD_W-1:0]     in_request_size,
  input  logic [pba_pkg::FIELD_W-1:0]     in_block_address,
  input  pba_pkg::pba_cmd_t               cmd,
  output pba_pkg::pba_sts_t               sts,
  output logic [pba_pkg::FIELD_W-1:0]     out_granted_address,
  output logic [pba_pkg::STATUS_W-1:0]    out_status
);
  import pba_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int DW = ADDR_BITS + LEN_W + 1;
  localparam int SW = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;

  // configuration
  logic [FIELD_W-1:0] pool_limit_r;
  logic [FIELD_W-1:0] start_offset_r;
  logic               locked_r;

  // request
  logic                 mode_r;
  logic [LEN_W-1:0]     size_r;
  logic [ADDR_BITS-1:0] where_r;

  // table walk
  logic [CW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        idx_r;
  logic                 rd_valid_r, rd_top_r;
  logic [IW-1:0]        rd_idx_r;
  logic                 found_r;
  logic [LEN_W-1:0]     best_len_r;
  logic [IW-1:0]        pick_idx_r;
  logic [ADDR_BITS-1:0] pick_addr_r;
  logic [LEN_W-1:0]     pick_len_r;
  logic [ADDR_BITS-1:0] end_r;

  // result
  logic [FIELD_W-1:0]  addr_out_r;
  logic [STATUS_W-1:0] status_out_r;

  // RAM
  logic                 ram_we, ram_re;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  logic [DW-1:0]        ram_wdata, ram_rdata;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [LEN_W-1:0]     rd_len;
  logic                 rd_free;

  // alignment
  logic                 al_start;
  logic [ADDR_BITS-1:0] al_value, al_rounded;

  logic                 bad, early, top_read, scan_hit;
  logic [ADDR_BITS-1:0] top_end;
  logic                 no_mem, pick_is_top;
  logic [STATUS_W-1:0]  status_d;
  logic [FIELD_W-1:0]   addr_d;

  assign rd_addr = ram_rdata[ADDR_BITS-1:0];
  assign rd_len  = ram_rdata[ADDR_BITS +: LEN_W];
  assign rd_free = ram_rdata[DW-1];

  assign bad   = (mode_r == MODE_ALLOC) && (size_r == '0 || pool_limit_r == '0);
  assign early = locked_r || bad;

  assign top_read = cmd.prep && !early && (mode_r == MODE_ALLOC) && (count_r != '0);
  assign ram_re    = top_read || cmd.scan;
  assign ram_raddr = cmd.scan ? idx_r : IW'(count_r - CW'(1));

  assign top_end  = rd_addr + ADDR_BITS'(rd_len);
  assign al_start = (cmd.prep && !early && (mode_r == MODE_ALLOC) && (count_r == '0))
                 || (rd_valid_r && rd_top_r);
  assign al_value = (rd_valid_r && rd_top_r) ? top_end : ADDR_BITS'(start_offset_r);

  always_comb begin
    if (mode_r == MODE_ALLOC) begin
      scan_hit = rd_free && (rd_len >= size_r) && (rd_len < pool_limit_r)
              && (!found_r || rd_len < best_len_r);
    end else begin
      scan_hit = !found_r && (rd_addr == where_r);
    end
  end

  assign sts.early     = early;
  assign sts.empty     = (count_r == '0);
  assign sts.scan_last = (CW'(idx_r) == count_r - CW'(1));
  assign sts.busy      = rd_valid_r;

  // end of a later block is checked without overflow in a widened sum
  assign no_mem = (count_r == '0) ? (size_r > pool_limit_r)
                : (SW'(end_r) + SW'(size_r) > SW'(pool_limit_r));
  assign pick_is_top = (CW'(pick_idx_r) == count_r - CW'(1));

  always_comb begin
    status_d  = ST_NOT_FOUND;
    addr_d    = '0;
    count_nxt = count_r;
    ram_we    = 1'b0;
    ram_waddr = pick_idx_r;
    ram_wdata = {1'b0, pick_len_r, pick_addr_r};
    priority if (locked_r) begin
      status_d = ST_LOCKED;
    end else if (mode_r == MODE_ALLOC) begin
      priority if (bad) begin
        status_d = ST_BAD;
      end else if (found_r) begin
        status_d = ST_REUSED;
        addr_d   = FIELD_W'(pick_addr_r);
        ram_we   = cmd.finish;
      end else if (count_r == CW'(MAX_BLOCKS)) begin
        status_d = ST_FULL;
      end else if (no_mem) begin
        status_d = ST_NO_MEMORY;
      end else begin
        status_d  = ST_NEW;
        addr_d    = FIELD_W'(al_rounded);
        ram_we    = cmd.finish;
        ram_waddr = IW'(count_r);
        ram_wdata = {1'b0, size_r, al_rounded};
        count_nxt = count_r + CW'(1);
      end
    end else if (found_r) begin
      if (pick_is_top) begin
        status_d  = ST_TOP_REMOVED;
        count_nxt = count_r - CW'(1);
      end else begin
        status_d  = ST_FREED;
        ram_we    = cmd.finish;
        ram_wdata = {1'b1, pick_len_r, pick_addr_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_limit_r   <= '0;
      start_offset_r <= '0;
      locked_r       <= 1'b0;
      count_r        <= '0;
      rd_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POOL_LIMIT:   pool_limit_r   <= cfg_data;
          CFG_START_OFFSET: start_offset_r <= cfg_data;
          CFG_LOCKED:       locked_r       <= cfg_data[0];
          default: ;
        endcase
      end
      rd_valid_r <= ram_re;
      if (cmd.finish) begin
        count_r <= count_nxt;
      end
    end

    rd_top_r <= top_read;
    rd_idx_r <= idx_r;

    if (cmd.load) begin
      mode_r  <= in_mode;
      size_r  <= in_request_size;
      where_r <= ADDR_BITS'(in_block_address);
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (cmd.scan) begin
        idx_r <= idx_r + IW'(1);
      end
      if (rd_valid_r && !rd_top_r && scan_hit) begin
        found_r     <= 1'b1;
        best_len_r  <= rd_len;
        pick_idx_r  <= rd_idx_r;
        pick_addr_r <= rd_addr;
        pick_len_r  <= rd_len;
      end
    end

    if (rd_valid_r && rd_top_r) begin
      end_r <= top_end;
    end

    if (cmd.finish) begin
      addr_out_r   <= addr_d;
      status_out_r <= status_d;
    end
  end

  pba_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pba_align #(
    .ADDR_BITS   (ADDR_BITS),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_align (
    .clk     (clk),
    .start   (al_start),
    .value   (al_value),
    .rounded (al_rounded)
  );

  assign out_granted_address = addr_out_r;
  assign out_status          = status_out_r;

endmodule

// File: hdl/pool_block_allocator_core.sv
// Top level of the pool block allocator: controller plus datapath.
// Depends on pba_pkg, pba_in_if, pba_out_if, pba_ctrl and pba_dpath.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------
//  in_ch   | in  | valid/ready | mode, request_size, block_address
//  out_ch  | out | valid/ready | granted_address, status
//  cfg_*   | in  | cfg_we only | cfg_index, cfg_data (no read-back)
//
// One request at a time; out_ch.valid rises on the edge after the finish.
// Locked or bad requests go from prep straight to finish, and any request on
// an empty table skips the walk. Otherwise one RAM read port walks the table
// one entry a cycle, an allocate reads the top entry first, the last read drains.
// Alignment is an add and mask with a registered result. A new beat is taken
// while the last result still waits; the finish then stalls until it goes.
// Reset clears the entry count, the config registers and the controller state;
// the table needs no clearing pass.
// ALIGN_BYTES must be a power of two.
module pool_block_allocator_core #(
  parameter int MAX_BLOCKS  = 64,
  parameter int ADDR_BITS   = 32,
  parameter int ALIGN_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pba_in_if.sink                        in_ch,
  pba_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pba_pkg::FIELD_W-1:0]   cfg_data
);
  import pba_pkg::*;

  pba_cmd_t cmd;
  pba_sts_t sts;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pba_dpath #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .ADDR_BITS   (ADDR_BITS),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_mode             (in_ch.mode),
    .in_request_size     (in_ch.request_size),
    .in_block_address    (in_ch.block_address),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_granted_address (out_ch.granted_address),
    .out_status          (out_ch.status)
  );

`ifndef SYNTH
  // one request in flight: ready drops straight after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.prep, cmd.scan, cmd.finish}))
    else $error("controller issued more than one command");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !sts.busy)
    else $error("result decided while walk or alignment still running");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.finish))
    else $error("result beat raised without a finish");
`endif

endmodule
